### sv/bda_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

  localparam int ValueWidth = 16;
  localparam int DigitWidth = 4;
  localparam int CharWidth  = 6;
  localparam int MaxDigits  = 5;
  localparam int CountWidth = 3;

  // Division by ten of a 16-bit value: q = (v * 52429) >> 19, exact for every 16-bit v.
  localparam logic [16:0] RecipTen   = 17'd52429;
  localparam int          RecipShift = 19;

  localparam logic [CharWidth-1:0] AsciiZero = 6'd48;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the input value, clear the digit stack
    logic step;   // divide by ten once and push the remainder digit
    logic pop;    // drop the digit that was just delivered
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;  // the current step produces the final digit
    logic last;       // the digit on the output is the least significant one
  } stat_t;

endpackage

`default_nettype wire

### sv/bda_ctrl.sv
// Controller state machine for the binary to decimal ASCII converter.
// Depends on bda_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module bda_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire bda_pkg::stat_t stat,
  output bda_pkg::cmd_t      cmd
);
  import bda_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (stat.conv_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          cmd.pop = 1'b1;
          if (stat.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/bda_dpath.sv
// Datapath for the binary to decimal ASCII converter: divide-by-ten unit,
// digit stack and ASCII output. Depends on bda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bda_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire bda_pkg::cmd_t                        cmd,
  input  wire logic [bda_pkg::ValueWidth-1:0]       value,
  output bda_pkg::stat_t                            stat,
  output logic [bda_pkg::CharWidth-1:0]             digit_char,
  output logic                                      last_digit
);
  import bda_pkg::*;

  logic [ValueWidth-1:0] val;
  logic [DigitWidth-1:0] digs [MaxDigits];
  logic [CountWidth-1:0] cnt;

  logic [ValueWidth+16:0] prod;
  logic [ValueWidth-1:0]  quot;
  logic [ValueWidth-1:0]  quot_x10;
  logic [ValueWidth-1:0]  rem_full;
  logic [DigitWidth-1:0]  rem;

  assign prod     = val * RecipTen;
  assign quot     = ValueWidth'(prod >> RecipShift);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem_full = val - quot_x10;
  assign rem      = rem_full[DigitWidth-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val <= value;
    end else if (cmd.step) begin
      val <= quot;
    end
  end

  // The newest digit sits at the top of the stack and is delivered first.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      digs[0] <= rem;
      for (int i = 1; i < MaxDigits; i++) begin
        digs[i] <= digs[i-1];
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < MaxDigits-1; i++) begin
        digs[i] <= digs[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      cnt <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  assign stat.conv_done = (quot == '0) || (cnt == CountWidth'(MaxDigits - 1));
  assign stat.last      = (cnt == CountWidth'(1));

  assign digit_char = AsciiZero + {{(CharWidth-DigitWidth){1'b0}}, digs[0]};
  assign last_digit = stat.last;

endmodule

`default_nettype wire

### sv/binary_to_decimal_ascii_core.sv
// Unsigned 16-bit binary to decimal ASCII converter, most significant digit first.
// An accepted request is converted at one digit per cycle (1 to 5 digits), and the
// first digit is shown in the cycle after the last step; digits then follow at one
// per cycle while out_ready is high. The single divide-by-ten unit and the serial
// output take one request at a time. Reset returns to idle, no digits.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [bda_pkg::ValueWidth-1:0]       value,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [bda_pkg::CharWidth-1:0]             digit_char,
  output logic                                      last_digit
);
  import bda_pkg::*;

  // The controller sequences load, conversion and delivery; the datapath holds
  // the remaining value, the digit stack and the digit count.
  cmd_t  cmd;
  stat_t stat;

  bda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Each conversion step divides by ten with a reciprocal multiply and pushes the
  // remainder; digits come back off the stack in reverse order, which is the
  // most significant first. A zero request still produces one '0' digit.
  bda_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value      (value),
    .stat       (stat),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

endmodule

`default_nettype wire

### sv/bda_checker.sv
// Port-level checks for binary_to_decimal_ascii_core, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module bda_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] digit_char,
  input wire logic       last_digit
);

  // Once a request is taken, the input drops ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again while a request is in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("output valid while idle");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= 6'd48 && digit_char <= 6'd57))
    else $error("digit out of ASCII range");

  a_next_digit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_digit) |=> out_valid)
    else $error("digit stream broken before last digit");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_digit) |=> in_ready)
    else $error("not idle after last digit");

endmodule

bind binary_to_decimal_ascii_core bda_checker u_bda_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .digit_char (digit_char),
  .last_digit (last_digit)
);

`default_nettype wire

### sim/binary_to_decimal_ascii_checker.sv
// Checker for the binary to decimal ASCII converter: watches both channels,
// predicts the decimal digits of every accepted value and compares each delivered digit.
// Depends on bda_pkg for the field widths and the ASCII code of '0'.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [bda_pkg::ValueWidth-1:0] value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [bda_pkg::CharWidth-1:0]  digit_char,
  input  logic                           last_digit,
  output int                             fail_count,
  output int                             pending,
  output int                             requests_seen,
  output int                             digits_seen
);
  import bda_pkg::*;

  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic                 last;
  } digit_rec_t;

  digit_rec_t expected_digits[$];

  // Splits a value into decimal digits and queues them most significant first.
  task automatic queue_decimal_text(input logic [ValueWidth-1:0] v);
    logic [3:0] digs [MaxDigits];
    int         n;
    int         rest;
    digit_rec_t rec;
    rest = v;
    n = 0;
    do begin
      digs[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end while (rest != 0 && n < MaxDigits);
    for (int k = n - 1; k >= 0; k--) begin
      rec.ch   = AsciiZero + CharWidth'(digs[k]);
      rec.last = (k == 0);
      expected_digits.push_back(rec);
    end
  endtask

  always @(posedge clk) begin : watch
    digit_rec_t want;
    logic       bad;
    if (rst) begin
      expected_digits.delete();
      fail_count    <= 0;
      pending       <= 0;
      requests_seen <= 0;
      digits_seen   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        digits_seen <= digits_seen + 1;
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected digit: digit_char %0d last_digit %0b",
                   $time, digit_char, last_digit);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_digits.pop_front();
          bad  = 1'b0;
          if (digit_char !== want.ch) begin
            $display("%0t: digit_char mismatch: expected %0d actual %0d",
                     $time, want.ch, digit_char);
            bad = 1'b1;
          end
          if (last_digit !== want.last) begin
            $display("%0t: last_digit mismatch: expected %0b actual %0b",
                     $time, want.last, last_digit);
            bad = 1'b1;
          end
          if (bad) fail_count <= fail_count + 1;
        end
      end
      if (in_valid && in_ready) begin
        queue_decimal_text(value);
        requests_seen <= requests_seen + 1;
      end
      pending <= expected_digits.size();
    end
  end

endmodule

### sim/binary_to_decimal_ascii_core_test.sv
// Top of the testbench for binary_to_decimal_ascii_core: clock, reset, request stimulus,
// output back-pressure and the verdict. Depends on bda_pkg, the core and the checker.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_core_test;
  import bda_pkg::*;

  localparam int RandomRequests = 330;
  localparam int HoldCycles     = 200;
  localparam int DrainCycles    = 20;
  localparam int DrainLimit     = 5000;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [ValueWidth-1:0] value;
  logic                  out_valid;
  logic                  out_ready;
  logic [CharWidth-1:0]  digit_char;
  logic                  last_digit;

  int fail_count;
  int pending;
  int requests_seen;
  int digits_seen;

  // When steady is set, neither side inserts random idle cycles.
  bit steady;
  // The sender raises hold_off to ask the receiver for one long stall.
  bit hold_off;
  int hold_cnt;

  binary_to_decimal_ascii_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  binary_to_decimal_ascii_checker check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digit_char    (digit_char),
    .last_digit    (last_digit),
    .fail_count    (fail_count),
    .pending       (pending),
    .requests_seen (requests_seen),
    .digits_seen   (digits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one request. Inputs only change on the falling edge, and every idle cycle
  // and the final raise of in_valid fall on distinct falling edges, so in_valid never
  // sees two assignments in one time step. The request is held until accepted.
  task automatic send_request(input logic [ValueWidth-1:0] v);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering requests until every predicted digit has been delivered.
  task automatic drain_pause();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Random values in several flavors: raw 16-bit patterns so that every input bit
  // toggles, a uniform pick of the digit count so that short and long numbers are
  // equally common, values at or just below a power of ten, and small numbers.
  function automatic logic [ValueWidth-1:0] pick_value();
    logic [31:0] raw;
    int          digits;
    int          lo;
    int          hi;
    int          base;
    raw = $urandom;
    case ($urandom_range(3))
      0: return raw[ValueWidth-1:0];
      1: begin
        digits = $urandom_range(MaxDigits, 1);
        lo = 1;
        for (int i = 1; i < digits; i++) lo = lo * 10;
        hi = (digits == MaxDigits) ? 65535 : lo * 10 - 1;
        if (digits == 1) lo = 0;
        return ValueWidth'($urandom_range(hi, lo));
      end
      2: begin
        base = 1;
        for (int i = $urandom_range(4, 1); i > 0; i--) base = base * 10;
        return ValueWidth'(base - 1 + $urandom_range(1));
      end
      default: return ValueWidth'($urandom_range(99));
    endcase
  endfunction

  // Receiver: random back-pressure, except during the steady stretch and during the
  // one long hold-off, which is counted here so that the sender keeps pushing requests
  // into the core until its input stalls.
  initial begin
    out_ready = 1'b0;
    hold_cnt  = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        hold_cnt = HoldCycles;
      end
      if (hold_cnt > 0) begin
        out_ready <= 1'b0;
        hold_cnt--;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 14);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int failures;
    rst      = 1'b1;
    in_valid = 1'b0;
    value    = '0;
    steady   = 1'b0;
    hold_off = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests: zero, single digits, both sides of every power of ten,
    // the largest value and alternating bit patterns.
    send_request(16'd0);
    send_request(16'd1);
    send_request(16'd9);
    send_request(16'd10);
    send_request(16'd99);
    send_request(16'd100);
    send_request(16'd999);
    send_request(16'd1000);
    send_request(16'd9999);
    send_request(16'd10000);
    send_request(16'd65535);
    send_request(16'd65534);
    send_request(16'h8000);
    send_request(16'h5555);
    send_request(16'hAAAA);
    send_request(16'd12345);
    send_request(16'd54321);
    send_request(16'd60000);
    send_request(16'd10101);
    send_request(16'd0);
    send_request(16'd7);
    drain_pause();

    // Random requests with a long stall of the receiver early on, a stretch with no
    // idling on either side and a second full drain of the core.
    for (int n = 0; n < RandomRequests; n++) begin
      if (n == 40) hold_off = 1'b1;
      if (n == 120) steady = 1'b1;
      if (n == 200) steady = 1'b0;
      if (n == 250) drain_pause();
      send_request(pick_value());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Let the last digits come out, then give the core a few more cycles so that any
    // stray output would still be caught.
    for (int i = 0; i < DrainLimit && pending != 0; i++) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    failures = fail_count;
    if (pending != 0) begin
      $display("%0t: %0d expected digits never delivered", $time, pending);
      failures++;
    end
    $display("Converted %0d requests into %0d digits: decade edges, random values,",
             requests_seen, digits_seen);
    $display("a long output stall, a steady stretch and drain pauses.");
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
